@@ rtl/core/mwm_pkg.sv @@
// mwm_pkg: command and result beat types and fixed constants of the mecanum wheel mixer
// depends on nothing; used by mwm_divider and mecanum_wheel_mixer
package mwm_pkg;

  // fixed field widths
  localparam int CMD_W  = 16;
  localparam int MAG_W  = CMD_W + 1;  // magnitude of a 16 bit value, -32768 included
  localparam int SUM_W  = MAG_W;      // three magnitudes sum to at most 98304
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index decoded from paddr[2]
  localparam logic REG_ROLLER_LAYOUT = 1'b0;

  typedef struct packed {
    logic signed [CMD_W-1:0] strafe_velocity;
    logic signed [CMD_W-1:0] forward_velocity;
    logic signed [CMD_W-1:0] rotation_velocity;
  } mwm_cmd_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] front_left_speed;
    logic signed [CMD_W-1:0] front_right_speed;
    logic signed [CMD_W-1:0] rear_left_speed;
    logic signed [CMD_W-1:0] rear_right_speed;
    logic                    inputs_scaled;
  } mwm_result_t;

  // side data that travels with a beat through the divider
  typedef struct packed {
    mwm_cmd_t cmd;
    logic     scaled;
  } mwm_tag_t;

endpackage

@@ rtl/core/mwm_divider.sv @@
// mwm_divider: pipelined restoring divider, three numerators over one shared divisor
// one quotient bit per stage; depends on mwm_pkg
module mwm_divider #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  mwm_pkg::mwm_tag_t                      in_tag,
  input  logic [mwm_pkg::SUM_W-1:0]              in_divisor,
  input  logic [2:0][mwm_pkg::MAG_W-1:0]         in_mag,
  output logic                                   out_valid,
  output mwm_pkg::mwm_tag_t                      out_tag,
  output logic [2:0][FRAC_BITS:0]                out_quot
);

  localparam int Q_W = FRAC_BITS + 1;
  localparam int R_W = mwm_pkg::SUM_W + 1;

  // stage registers
  logic                         vld [Q_W];
  mwm_pkg::mwm_tag_t            tag [Q_W];
  logic [mwm_pkg::SUM_W-1:0]    dvs [Q_W];
  logic [2:0][R_W-1:0]          rem [Q_W];
  logic [2:0][Q_W-1:0]          quo [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic                      p_valid;
    mwm_pkg::mwm_tag_t         p_tag;
    logic [mwm_pkg::SUM_W-1:0] p_dvs;
    logic [2:0][R_W-1:0]       p_rem;
    logic [2:0][Q_W-1:0]       p_quo;
    logic [2:0][R_W-1:0]       n_rem;
    logic [2:0][Q_W-1:0]       n_quo;

    // previous stage, or the input beat for the first one
    if (i == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_tag   = in_tag;
      assign p_dvs   = in_divisor;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign p_rem[k] = {{(R_W-mwm_pkg::MAG_W){1'b0}}, in_mag[k]};
      end
      assign p_quo = '0;
    end else begin : g_next
      assign p_valid = vld[i-1];
      assign p_tag   = tag[i-1];
      assign p_dvs   = dvs[i-1];
      assign p_rem   = rem[i-1];
      assign p_quo   = quo[i-1];
    end

    // one compare and subtract per lane, remainder stays below the divisor
    always_comb begin
      logic [R_W:0]   diff;
      logic           take;
      logic [R_W-1:0] kept;
      for (int k = 0; k < 3; k++) begin
        diff     = {1'b0, p_rem[k]} - {2'b00, p_dvs};
        take     = ~diff[R_W];
        kept     = take ? diff[R_W-1:0] : p_rem[k];
        n_rem[k] = {kept[R_W-2:0], 1'b0};
        n_quo[k] = {p_quo[k][Q_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= p_valid;
      end
      tag[i] <= p_tag;
      dvs[i] <= p_dvs;
      rem[i] <= n_rem;
      quo[i] <= n_quo;
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_tag   = tag[Q_W-1];
  assign out_quot  = quo[Q_W-1];

  // checks
  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##Q_W out_valid)
    else $error("divider lost a beat");

  a_div_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, Q_W))
    else $error("divider beat with no input beat");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tag.scaled |->
      (out_quot[0] <= ONE) && (out_quot[1] <= ONE) && (out_quot[2] <= ONE))
    else $error("scaled quotient above one");

endmodule

@@ rtl/core/mecanum_wheel_mixer.sv @@
// mecanum_wheel_mixer: inverse kinematics for a four wheel mecanum drive
// stages: one magnitude/sum stage, FRAC_BITS+1 divider stages, one mix stage
// throughput: one command per cycle, busy never rises; the divider is fully pipelined
// reset: synchronous rst clears roller_layout and all valid bits; data registers are not reset
// depends on mwm_pkg and mwm_divider
module mecanum_wheel_mixer #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]  paddr,
  input  logic [mwm_pkg::DATA_W-1:0]  pwdata,
  output logic [mwm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  mwm_pkg::mwm_cmd_t           cmd,
  output logic                        done,
  output mwm_pkg::mwm_result_t        result
);

  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CMP_W = (mwm_pkg::SUM_W > FRAC_BITS + 2) ? mwm_pkg::SUM_W : FRAC_BITS + 2;
  localparam int T_W   = (Q_W + 1 > mwm_pkg::CMD_W + 1) ? Q_W + 1 : mwm_pkg::CMD_W + 1;
  localparam int W_W   = T_W + 2;
  localparam logic [CMP_W-1:0]      ONE    = CMP_W'(1) << FRAC_BITS;
  localparam logic signed [W_W-1:0] SAT_HI = W_W'(32767);
  localparam logic signed [W_W-1:0] SAT_LO = -W_W'(32768);

  // configuration port
  logic roller_layout;
  logic cfg_write;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      roller_layout <= 1'b0;
    end else if (cfg_write && paddr[2] == mwm_pkg::REG_ROLLER_LAYOUT) begin
      roller_layout <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mwm_pkg::REG_ROLLER_LAYOUT) begin
      prdata[0] = roller_layout;
    end
  end

  // stage 0: magnitudes, their sum and the scale decision
  logic                        in_beat;
  logic [2:0][mwm_pkg::MAG_W-1:0] mag;
  logic [mwm_pkg::SUM_W-1:0]   mag_sum;
  logic                        s0_valid;
  mwm_pkg::mwm_tag_t           s0_tag;
  logic [mwm_pkg::SUM_W-1:0]   s0_sum;
  logic [2:0][mwm_pkg::MAG_W-1:0] s0_mag;

  assign in_beat = start && !busy;

  always_comb begin
    logic signed [mwm_pkg::MAG_W-1:0] v [3];
    v[0] = {cmd.strafe_velocity[mwm_pkg::CMD_W-1],   cmd.strafe_velocity};
    v[1] = {cmd.forward_velocity[mwm_pkg::CMD_W-1],  cmd.forward_velocity};
    v[2] = {cmd.rotation_velocity[mwm_pkg::CMD_W-1], cmd.rotation_velocity};
    for (int k = 0; k < 3; k++) begin
      mag[k] = v[k][mwm_pkg::MAG_W-1] ? mwm_pkg::MAG_W'(-v[k]) : mwm_pkg::MAG_W'(v[k]);
    end
    mag_sum = mag[0] + mag[1] + mag[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_beat;
    end
    s0_tag.cmd    <= cmd;
    s0_tag.scaled <= CMP_W'(mag_sum) > ONE;
    s0_sum        <= mag_sum;
    s0_mag        <= mag;
  end

  // divider: |v| * ONE / sum for each command
  logic                 dv_valid;
  mwm_pkg::mwm_tag_t    dv_tag;
  logic [2:0][Q_W-1:0]  dv_quot;

  mwm_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s0_valid),
    .in_tag     (s0_tag),
    .in_divisor (s0_sum),
    .in_mag     (s0_mag),
    .out_valid  (dv_valid),
    .out_tag    (dv_tag),
    .out_quot   (dv_quot)
  );

  // mix stage: restore signs, pick scaled or raw terms, form and saturate wheel sums
  mwm_pkg::mwm_result_t result_next;

  always_comb begin
    logic signed [T_W-1:0] raw  [3];
    logic signed [T_W-1:0] term [3];
    logic signed [T_W-1:0] sx;
    logic signed [W_W-1:0] w    [4];
    logic signed [mwm_pkg::CMD_W-1:0] sat [4];
    raw[0] = T_W'(dv_tag.cmd.strafe_velocity);
    raw[1] = T_W'(dv_tag.cmd.forward_velocity);
    raw[2] = T_W'(dv_tag.cmd.rotation_velocity);
    for (int k = 0; k < 3; k++) begin
      if (dv_tag.scaled) begin
        term[k] = raw[k][T_W-1] ? -T_W'(dv_quot[k]) : T_W'(dv_quot[k]);
      end else begin
        term[k] = raw[k];
      end
    end
    sx   = roller_layout ? -term[0] : term[0];
    w[0] = -W_W'(sx) + W_W'(term[1]) + W_W'(term[2]);
    w[1] =  W_W'(sx) + W_W'(term[1]) - W_W'(term[2]);
    w[2] =  W_W'(sx) + W_W'(term[1]) + W_W'(term[2]);
    w[3] = -W_W'(sx) + W_W'(term[1]) - W_W'(term[2]);
    for (int j = 0; j < 4; j++) begin
      if (w[j] > SAT_HI) begin
        sat[j] = 16'sh7fff;
      end else if (w[j] < SAT_LO) begin
        sat[j] = -16'sh8000;
      end else begin
        sat[j] = w[j][mwm_pkg::CMD_W-1:0];
      end
    end
    result_next.front_left_speed  = sat[0];
    result_next.front_right_speed = sat[1];
    result_next.rear_left_speed   = sat[2];
    result_next.rear_right_speed  = sat[3];
    result_next.inputs_scaled     = dv_tag.scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    result <= result_next;
  end

  // checks
  localparam int LAT   = FRAC_BITS + 3;
  localparam int ONE_I = 1 << FRAC_BITS;

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> ##LAT done)
    else $error("command beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_beat, LAT))
    else $error("result without a command beat");

  a_scaled_bound: assert property (@(posedge clk) disable iff (rst)
    done && result.inputs_scaled |->
      (int'(result.front_left_speed)  <= ONE_I) && (int'(result.front_left_speed)  >= -ONE_I) &&
      (int'(result.front_right_speed) <= ONE_I) && (int'(result.front_right_speed) >= -ONE_I) &&
      (int'(result.rear_left_speed)   <= ONE_I) && (int'(result.rear_left_speed)   >= -ONE_I) &&
      (int'(result.rear_right_speed)  <= ONE_I) && (int'(result.rear_right_speed)  >= -ONE_I))
    else $error("normalized wheel speed beyond one");

endmodule

@@ dv/mwm_result_checker.sv @@
`timescale 1ns / 100ps
// mwm_result_checker: predicts each wheel speed beat of the mecanum wheel mixer and checks it
// in order; follows roller_layout from the APB writes. depends on mwm_pkg
module mwm_result_checker #(
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [mwm_pkg::ADDR_W-1:0] paddr,
  input  logic [mwm_pkg::DATA_W-1:0] pwdata,
  input  logic                       start,
  input  logic                       busy,
  input  mwm_pkg::mwm_cmd_t          cmd,
  input  logic                       done,
  input  mwm_pkg::mwm_result_t       result,
  output int                         fail_count,
  output int                         pending_count,
  output int                         checked_count,
  output int                         scaled_count
);

  localparam longint ONE = longint'(1) << FRAC_BITS;

  typedef struct packed {
    mwm_pkg::mwm_cmd_t    cmd;
    mwm_pkg::mwm_result_t speeds;
  } wheel_beat_t;

  logic        roller_layout = 1'b0;
  wheel_beat_t expected_speeds_q[$];
  int          fails = 0;
  int          pending = 0;
  int          checked = 0;
  int          scaled = 0;

  assign fail_count    = fails;
  assign pending_count = pending;
  assign checked_count = checked;
  assign scaled_count  = scaled;

  // clamp a wide wheel speed to the 16 bit result field
  function automatic logic signed [mwm_pkg::CMD_W-1:0] saturate16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[mwm_pkg::CMD_W-1:0];
  endfunction

  // normalize the command if the sum of its magnitudes exceeds 1.0, then mix into four wheels
  function automatic mwm_pkg::mwm_result_t mix_wheel_speeds(mwm_pkg::mwm_cmd_t c,
                                                            logic layout);
    longint               x;
    longint               y;
    longint               r;
    longint               total;
    longint               sx;
    mwm_pkg::mwm_result_t speeds;
    x = c.strafe_velocity;
    y = c.forward_velocity;
    r = c.rotation_velocity;
    total = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (r < 0 ? -r : r);
    speeds.inputs_scaled = (total > ONE);
    if (speeds.inputs_scaled) begin
      // integer division truncates toward zero
      x = (x * ONE) / total;
      y = (y * ONE) / total;
      r = (r * ONE) / total;
    end
    // swapped roller layout flips the strafe term
    sx = layout ? -x : x;
    speeds.front_left_speed  = saturate16(-sx + y + r);
    speeds.front_right_speed = saturate16(sx + y - r);
    speeds.rear_left_speed   = saturate16(sx + y + r);
    speeds.rear_right_speed  = saturate16(-sx + y - r);
    return speeds;
  endfunction

  task automatic report_failure(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string name, logic signed [mwm_pkg::CMD_W:0] got,
                             logic signed [mwm_pkg::CMD_W:0] want, mwm_pkg::mwm_cmd_t c);
    if (got !== want)
      report_failure($sformatf("%s got %0d expected %0d for command x=%0d y=%0d r=%0d",
                               name, got, want, c.strafe_velocity, c.forward_velocity,
                               c.rotation_velocity));
  endtask

  always @(posedge clk) begin : monitor
    wheel_beat_t want;
    if (rst) begin
      roller_layout = 1'b0;
    end else begin
      // register write lands in the access phase
      if (psel && penable && pwrite && pready &&
          paddr[mwm_pkg::ADDR_W-1:2] == mwm_pkg::REG_ROLLER_LAYOUT)
        roller_layout = pwdata[0];

      // result beat against the oldest expectation
      if (done) begin
        if (expected_speeds_q.size() == 0) begin
          report_failure("result beat with no command outstanding");
        end else begin
          want = expected_speeds_q.pop_front();
          pending--;
          checked++;
          check_field("front_left_speed", result.front_left_speed,
                      want.speeds.front_left_speed, want.cmd);
          check_field("front_right_speed", result.front_right_speed,
                      want.speeds.front_right_speed, want.cmd);
          check_field("rear_left_speed", result.rear_left_speed,
                      want.speeds.rear_left_speed, want.cmd);
          check_field("rear_right_speed", result.rear_right_speed,
                      want.speeds.rear_right_speed, want.cmd);
          check_field("inputs_scaled", result.inputs_scaled,
                      want.speeds.inputs_scaled, want.cmd);
        end
      end

      // command beat accepted
      if (start && !busy) begin
        want.cmd    = cmd;
        want.speeds = mix_wheel_speeds(cmd, roller_layout);
        expected_speeds_q.push_back(want);
        pending++;
        if (want.speeds.inputs_scaled) scaled++;
      end
    end
  end

endmodule

@@ dv/tb_mecanum_wheel_mixer.sv @@
`timescale 1ns / 100ps
// tb_mecanum_wheel_mixer: directed and random command beats over both roller layouts
// depends on mwm_pkg, mecanum_wheel_mixer and mwm_result_checker
module tb_mecanum_wheel_mixer;

  localparam int FRAC_BITS     = 14;
  localparam int ONE           = 1 << FRAC_BITS;
  localparam int LATENCY       = FRAC_BITS + 3;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 4;
  localparam logic [mwm_pkg::ADDR_W-1:0] ADDR_ROLLER_LAYOUT =
    {mwm_pkg::REG_ROLLER_LAYOUT, 2'b00};
  localparam logic [mwm_pkg::ADDR_W-1:0] ADDR_UNMAPPED =
    {~mwm_pkg::REG_ROLLER_LAYOUT, 2'b00};

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mwm_pkg::ADDR_W-1:0] paddr;
  logic [mwm_pkg::DATA_W-1:0] pwdata;
  logic [mwm_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       start;
  logic                       busy;
  mwm_pkg::mwm_cmd_t          cmd;
  logic                       done;
  mwm_pkg::mwm_result_t       result;

  int                fail_count;
  int                pending_count;
  int                checked_count;
  int                scaled_count;
  bit                idling_on;
  int                sent_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  mecanum_wheel_mixer #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  mwm_result_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .fail_count(fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count),
    .scaled_count(scaled_count)
  );

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d result beats outstanding", pending_count);
    $display("tb_mecanum_wheel_mixer: FAIL");
    $finish;
  end

  // setup then access phase; called at a falling edge, returns at one
  task automatic apb_write(logic [mwm_pkg::ADDR_W-1:0] addr,
                           logic [mwm_pkg::DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // one command beat with an occasional idle burst ahead of it
  task automatic send_command(mwm_pkg::mwm_cmd_t c);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    cmd   = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sent_count++;
    @(negedge clk);
  endtask

  // hold off until every outstanding result beat is back
  task automatic drain_results();
    start = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic mwm_pkg::mwm_cmd_t random_command();
    int                a;
    int                b;
    int                c;
    mwm_pkg::mwm_cmd_t k;
    case ($urandom_range(0, 9))
      0, 1: begin
        // any 16 bit value, -32768 included
        k.strafe_velocity   = mwm_pkg::CMD_W'($urandom());
        k.forward_velocity  = mwm_pkg::CMD_W'($urandom());
        k.rotation_velocity = mwm_pkg::CMD_W'($urandom());
      end
      2, 3, 4: begin
        // magnitudes sum to at most 1.0, often exactly 1.0
        a = $urandom_range(0, ONE);
        b = $urandom_range(0, ONE - a);
        c = $urandom_range(0, 1) ? ONE - a - b : $urandom_range(0, ONE - a - b);
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
        if ($urandom_range(0, 1)) c = -c;
        case ($urandom_range(0, 2))
          0: k = '{a[mwm_pkg::CMD_W-1:0], b[mwm_pkg::CMD_W-1:0], c[mwm_pkg::CMD_W-1:0]};
          1: k = '{b[mwm_pkg::CMD_W-1:0], c[mwm_pkg::CMD_W-1:0], a[mwm_pkg::CMD_W-1:0]};
          default: k = '{c[mwm_pkg::CMD_W-1:0], a[mwm_pkg::CMD_W-1:0],
                         b[mwm_pkg::CMD_W-1:0]};
        endcase
      end
      default: begin
        // each command within +-1.0
        a = int'($urandom_range(0, 2 * ONE)) - ONE;
        b = int'($urandom_range(0, 2 * ONE)) - ONE;
        c = int'($urandom_range(0, 2 * ONE)) - ONE;
        k = '{a[mwm_pkg::CMD_W-1:0], b[mwm_pkg::CMD_W-1:0], c[mwm_pkg::CMD_W-1:0]};
      end
    endcase
    return k;
  endfunction

  initial begin : stimulus
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    cmd        = '0;
    idling_on  = 1'b0;
    sent_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apb_write(ADDR_ROLLER_LAYOUT, 32'h0);

    // all zero
    send_command('{16'sd0, 16'sd0, 16'sd0});
    // single axis at +-1.0
    send_command('{16'sd16384, 16'sd0, 16'sd0});
    send_command('{-16'sd16384, 16'sd0, 16'sd0});
    send_command('{16'sd0, 16'sd16384, 16'sd0});
    send_command('{16'sd0, -16'sd16384, 16'sd0});
    send_command('{16'sd0, 16'sd0, 16'sd16384});
    send_command('{16'sd0, 16'sd0, -16'sd16384});
    // magnitude sum exactly 1.0, then one lsb over
    send_command('{16'sd8192, 16'sd4096, 16'sd4096});
    send_command('{-16'sd8192, 16'sd4096, -16'sd4096});
    send_command('{16'sd8192, 16'sd4096, 16'sd4097});
    // commands beyond +-1.0, out to the 16 bit extremes
    send_command('{16'sh8000, 16'sh8000, 16'sh8000});
    send_command('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_command('{16'sh8000, 16'sh7fff, 16'sd0});
    send_command('{16'sh7fff, 16'sh8000, -16'sd1});
    send_command('{16'sd16384, 16'sd16384, 16'sd16384});
    send_command('{-16'sd16384, 16'sd16384, -16'sd16384});
    // smallest nonzero and alternating bit patterns
    send_command('{-16'sd1, -16'sd1, -16'sd1});
    send_command('{16'sd1, 16'sd1, 16'sd1});
    send_command('{16'sh5555, 16'shaaaa, 16'sh5555});
    send_command('{16'shaaaa, 16'sh5555, 16'shaaaa});
    drain_results();

    // random phases, each behind a register write on an idle block
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apb_write(ADDR_ROLLER_LAYOUT, 32'hffff_ffff);  // only bit 0 counts: layout 1
        1: apb_write(ADDR_UNMAPPED, 32'h0);               // ignored, layout stays 1
        2: apb_write(ADDR_ROLLER_LAYOUT, 32'hffff_fffe);  // layout 0
        default: apb_write(ADDR_ROLLER_LAYOUT, 32'h1);    // layout 1
      endcase
      idling_on = (phase != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_command(random_command());
      drain_results();
    end

    $display("sent %0d command beats (%0d normalized) across both roller layouts,",
             sent_count, scaled_count);
    $display("with an unmapped register write; %0d result beats checked", checked_count);
    if (fail_count == 0) begin
      $display("tb_mecanum_wheel_mixer: PASS");
    end else begin
      $display("tb_mecanum_wheel_mixer: FAIL");
    end
    $finish;
  end

endmodule
